@@ hw/rtl/twom_pkg.sv @@
// Shared types, constants and helpers for the three-wheel omni PWM mixer.
`default_nettype none

package twom_pkg;

    localparam int WHEELS       = 3;
    localparam int VEL_W        = 8;
    localparam int DUTY_W       = 8;
    localparam int SPD_W        = 25;
    localparam int MAG_W        = 24;
    localparam int QUO_W        = 8;
    localparam int NUM_W        = MAG_W + QUO_W;
    localparam int PROD_W       = 16;
    localparam int RECIP_W      = 28;
    localparam int RECIP_SHIFT  = 19;
    localparam int Q_ONE_SHIFT  = 15;
    localparam int Q_HALF_SHIFT = 14;

    localparam logic signed [SPD_W-1:0] SIN60_Q15 = 25'sd28378;
    localparam logic [12:0]             PCT_RECIP = 13'd5243;
    localparam logic [DUTY_W-1:0]       DUTY_MAX  = 8'd255;

    typedef logic signed [SPD_W-1:0] spd_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic [NUM_W-1:0]        num_t;
    typedef logic [QUO_W-1:0]        quo_t;
    typedef logic [DUTY_W-1:0]       duty_t;

    typedef struct packed {
        logic                stop;
        logic                zmax;
        logic [WHEELS-1:0]   fwd;
        duty_t               thr;
    } side_t;

    typedef struct packed {
        logic                valid;
        side_t               side;
        mag_t [WHEELS-1:0]   mag;
        mag_t                mmax;
        duty_t               diff;
    } kin_t;

    function automatic logic [VEL_W-1:0] abs8(input logic [VEL_W-1:0] v);
        logic [VEL_W-1:0] r;
        r = v[VEL_W-1] ? VEL_W'(-v) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/twom_kin.sv @@
// Wheel speeds, magnitudes, peak speed and duty span (four stages).
`default_nettype none

module twom_kin
    import twom_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [VEL_W-1:0]  vel_x,
    input  wire logic [VEL_W-1:0]  vel_y,
    input  wire logic [VEL_W-1:0]  turn_rate,
    input  wire duty_t             thr,
    output kin_t                   out
);

    // stage 1
    logic              v1_reg;
    spd_t [WHEELS-1:0] w1_reg;
    spd_t [WHEELS-1:0] w1_next;
    logic [VEL_W-1:0]  sp1_reg;
    logic [VEL_W-1:0]  sp1_next;
    logic              stop1_reg;
    duty_t             thr1_reg;

    // stage 2
    logic               v2_reg;
    mag_t [WHEELS-1:0]  m2_reg;
    mag_t [WHEELS-1:0]  m2_next;
    logic [WHEELS-1:0]  fwd2_reg;
    logic [WHEELS-1:0]  fwd2_next;
    logic [PROD_W-1:0]  p2_reg;
    logic [PROD_W-1:0]  p2_next;
    logic               stop2_reg;
    duty_t              thr2_reg;

    // stage 3
    logic               v3_reg;
    mag_t [WHEELS-1:0]  m3_reg;
    mag_t               mmax3_reg;
    mag_t               mmax3_next;
    logic [RECIP_W-1:0] q3_reg;
    logic [WHEELS-1:0]  fwd3_reg;
    logic               stop3_reg;
    duty_t              thr3_reg;

    // stage 4
    logic               v4_reg;
    mag_t [WHEELS-1:0]  m4_reg;
    mag_t               mmax4_reg;
    duty_t              diff4_reg;
    duty_t              diff4_next;
    logic [WHEELS-1:0]  fwd4_reg;
    logic               stop4_reg;
    duty_t              thr4_reg;

    spd_t              x_ext;
    spd_t              y_ext;
    spd_t              t_ext;
    spd_t              base;
    logic [VEL_W-1:0]  ax;
    logic [VEL_W-1:0]  ay;
    logic [RECIP_W-QUO_W-RECIP_SHIFT+QUO_W-1:0] pct;
    logic [DUTY_W+1:0] tsum;
    duty_t             target;

    always_comb
    begin
        x_ext = spd_t'(signed'(vel_x));
        y_ext = spd_t'(signed'(vel_y));
        t_ext = spd_t'(signed'(turn_rate));
        base  = -(t_ext <<< Q_ONE_SHIFT) - (x_ext <<< Q_HALF_SHIFT);
        w1_next[0] = base + y_ext * SIN60_Q15;
        w1_next[1] = base - y_ext * SIN60_Q15;
        w1_next[2] = (x_ext - t_ext) <<< Q_ONE_SHIFT;
        ax = abs8(vel_x);
        ay = abs8(vel_y);
        sp1_next = (ay > ax) ? ay : ax;
    end

    always_comb
    begin
        for (int k = 0; k < WHEELS; k++)
        begin
            m2_next[k]   = w1_reg[k][SPD_W-1] ? MAG_W'(-w1_reg[k]) : MAG_W'(w1_reg[k]);
            fwd2_next[k] = !w1_reg[k][SPD_W-1] && (w1_reg[k] != '0);
        end
        p2_next = PROD_W'(sp1_reg) * PROD_W'(DUTY_MAX - thr1_reg);
    end

    always_comb
    begin
        mmax3_next = m2_reg[0];
        if (m2_reg[1] > mmax3_next)
        begin
            mmax3_next = m2_reg[1];
        end
        if (m2_reg[2] > mmax3_next)
        begin
            mmax3_next = m2_reg[2];
        end
    end

    // floor(p / 100) via reciprocal, exact for p below 43690
    always_comb
    begin
        pct    = q3_reg[RECIP_W-1:RECIP_SHIFT];
        tsum   = (DUTY_W+2)'(thr3_reg) + (DUTY_W+2)'(pct);
        target = (tsum > (DUTY_W+2)'(DUTY_MAX)) ? DUTY_MAX : tsum[DUTY_W-1:0];
        diff4_next = target - thr3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg    <= w1_next;
        sp1_reg   <= sp1_next;
        stop1_reg <= (vel_x == '0) && (vel_y == '0);
        thr1_reg  <= thr;

        m2_reg    <= m2_next;
        fwd2_reg  <= fwd2_next;
        p2_reg    <= p2_next;
        stop2_reg <= stop1_reg;
        thr2_reg  <= thr1_reg;

        m3_reg    <= m2_reg;
        mmax3_reg <= mmax3_next;
        q3_reg    <= RECIP_W'(p2_reg) * RECIP_W'(PCT_RECIP);
        fwd3_reg  <= fwd2_reg;
        stop3_reg <= stop2_reg;
        thr3_reg  <= thr2_reg;

        m4_reg    <= m3_reg;
        mmax4_reg <= mmax3_reg;
        diff4_reg <= diff4_next;
        fwd4_reg  <= fwd3_reg;
        stop4_reg <= stop3_reg;
        thr4_reg  <= thr3_reg;
    end

    always_comb
    begin
        out.valid     = v4_reg;
        out.side.stop = stop4_reg;
        out.side.zmax = (mmax4_reg == '0);
        out.side.fwd  = fwd4_reg;
        out.side.thr  = thr4_reg;
        out.mag       = m4_reg;
        out.mmax      = mmax4_reg;
        out.diff      = diff4_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/twom_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, three lanes.
`default_nettype none

module twom_div
    import twom_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire side_t             in_side,
    input  wire num_t [WHEELS-1:0] in_num,
    input  wire mag_t              in_den,
    output logic                   out_valid,
    output side_t                  out_side,
    output quo_t [WHEELS-1:0]      out_quo
);

    logic              vld_reg  [QUO_W];
    side_t             side_reg [QUO_W];
    mag_t              den_reg  [QUO_W];
    num_t [WHEELS-1:0] rem_reg  [QUO_W];
    quo_t [WHEELS-1:0] quo_reg  [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_stage
            logic              vld_in;
            side_t             side_in;
            mag_t              den_in;
            num_t [WHEELS-1:0] rem_in;
            quo_t [WHEELS-1:0] quo_in;
            num_t [WHEELS-1:0] rem_next;
            quo_t [WHEELS-1:0] quo_next;
            num_t              dsh;

            if (s == 0)
            begin : g_first
                assign vld_in  = in_valid;
                assign side_in = in_side;
                assign den_in  = in_den;
                assign rem_in  = in_num;
                assign quo_in  = '0;
            end
            else
            begin : g_rest
                assign vld_in  = vld_reg[s-1];
                assign side_in = side_reg[s-1];
                assign den_in  = den_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign quo_in  = quo_reg[s-1];
            end

            always_comb
            begin
                dsh = NUM_W'(den_in) << (QUO_W - 1 - s);
                for (int k = 0; k < WHEELS; k++)
                begin
                    rem_next[k] = rem_in[k];
                    quo_next[k] = quo_in[k];
                    if (rem_in[k] >= dsh)
                    begin
                        rem_next[k] = rem_in[k] - dsh;
                        quo_next[k][QUO_W-1-s] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                side_reg[s] <= side_in;
                den_reg[s]  <= den_in;
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/three_wheel_omni_pwm_mixer.sv @@
// Top level of the three-wheel omni PWM mixer.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  command  | start / busy        | vel_x, vel_y, turn_rate
//  result   | done (1-cycle)      | duty_one..three, fwd_one..three,
//           |                     | drive_enable
//  config   | cfg_we              | cfg_data (pwm threshold)
//
// One item per cycle; busy is always low. Each command passes through
// four kinematics stages, one numerator multiply, eight divider stages
// (one quotient bit each) and the output register before its result shows.
// Reset clears the valid chain, the strobe and the threshold (to 0).
// The receiver cannot stall, so nothing ever holds in the pipeline.
`default_nettype none

module three_wheel_omni_pwm_mixer
    import twom_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [VEL_W-1:0]  vel_x,
    input  wire logic [VEL_W-1:0]  vel_y,
    input  wire logic [VEL_W-1:0]  turn_rate,
    input  wire logic              cfg_we,
    input  wire logic [DUTY_W-1:0] cfg_data,
    output logic                   done,
    output logic [DUTY_W-1:0]      duty_one,
    output logic                   fwd_one,
    output logic [DUTY_W-1:0]      duty_two,
    output logic                   fwd_two,
    output logic [DUTY_W-1:0]      duty_three,
    output logic                   fwd_three,
    output logic                   drive_enable
);

    duty_t             thr_reg;
    kin_t              kin;

    logic              v5_reg;
    side_t             side5_reg;
    mag_t              den5_reg;
    num_t [WHEELS-1:0] num5_reg;
    num_t [WHEELS-1:0] num5_next;

    logic              div_valid;
    side_t             div_side;
    quo_t [WHEELS-1:0] div_quo;

    logic               done_reg;
    duty_t [WHEELS-1:0] duty_reg;
    duty_t [WHEELS-1:0] duty_next;
    logic [WHEELS-1:0]  fwd_reg;
    logic               en_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    twom_kin u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .turn_rate (turn_rate),
        .thr       (thr_reg),
        .out       (kin)
    );

    always_comb
    begin
        for (int k = 0; k < WHEELS; k++)
        begin
            num5_next[k] = NUM_W'(kin.mag[k]) * NUM_W'(kin.diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= kin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side5_reg <= kin.side;
        den5_reg  <= kin.mmax;
        num5_reg  <= num5_next;
    end

    twom_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_side   (side5_reg),
        .in_num    (num5_reg),
        .in_den    (den5_reg),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quo   (div_quo)
    );

    always_comb
    begin
        for (int k = 0; k < WHEELS; k++)
        begin
            if (div_side.stop)
            begin
                duty_next[k] = '0;
            end
            else if (div_side.zmax)
            begin
                duty_next[k] = div_side.thr;
            end
            else
            begin
                duty_next[k] = div_side.thr + div_quo[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
        fwd_reg  <= div_side.stop ? '0 : div_side.fwd;
        en_reg   <= !div_side.stop;
    end

    assign done         = done_reg;
    assign duty_one     = duty_reg[0];
    assign fwd_one      = fwd_reg[0];
    assign duty_two     = duty_reg[1];
    assign fwd_two      = fwd_reg[1];
    assign duty_three   = duty_reg[2];
    assign fwd_three    = fwd_reg[2];
    assign drive_enable = en_reg;

endmodule

`default_nettype wire

@@ test/three_wheel_omni_pwm_mixer_tb.sv @@
// Testbench for the three-wheel omni PWM mixer: directed and random commands.
`default_nettype none

module three_wheel_omni_pwm_mixer_tb;
    import twom_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RESET_CYCLES  = 12;
    localparam int  SETTLE_CYCLES = 20;
    localparam int  STALL_LIMIT   = 4000;
    localparam int  PHASE_ITEMS   = 190;
    localparam int  MAX_REPORTS   = 10;
    localparam longint SIN60_Q15_K = 28378;
    localparam longint Q_ONE_K     = 32768;
    localparam longint Q_HALF_K    = 16384;
    localparam longint FULL_DUTY   = 255;
    localparam longint FULL_PCT    = 100;

    typedef struct packed {
        duty_t d1;
        logic  f1;
        duty_t d2;
        logic  f2;
        duty_t d3;
        logic  f3;
        logic  en;
    } drive_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [VEL_W-1:0]  vel_x = '0;
    logic [VEL_W-1:0]  vel_y = '0;
    logic [VEL_W-1:0]  turn_rate = '0;
    logic              cfg_we = 1'b0;
    logic [DUTY_W-1:0] cfg_data = '0;
    logic              done;
    logic [DUTY_W-1:0] duty_one;
    logic              fwd_one;
    logic [DUTY_W-1:0] duty_two;
    logic              fwd_two;
    logic [DUTY_W-1:0] duty_three;
    logic              fwd_three;
    logic              drive_enable;

    drive_t      pending_drives[$];
    logic [7:0]  thr_now = '0;
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_count = 0;

    three_wheel_omni_pwm_mixer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .turn_rate    (turn_rate),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .duty_one     (duty_one),
        .fwd_one      (fwd_one),
        .duty_two     (duty_two),
        .fwd_two      (fwd_two),
        .duty_three   (duty_three),
        .fwd_three    (fwd_three),
        .drive_enable (drive_enable)
    );

    always #10 clk = ~clk;

    function automatic longint abs_l(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic drive_t mix_wheels(input logic signed [7:0] x, input logic signed [7:0] y,
                                          input logic signed [7:0] t, input logic [7:0] thr);
        longint w[3];
        longint m[3];
        longint xs, ys, ts, sp, target, mmax, d, th;
        duty_t  duty[3];
        drive_t r;
        r = '0;
        xs = longint'(x);
        ys = longint'(y);
        ts = longint'(t);
        th = longint'(thr);
        if (xs == 0 && ys == 0)
            return r;
        w[0] = -Q_ONE_K * ts - Q_HALF_K * xs + SIN60_Q15_K * ys;
        w[1] = -Q_ONE_K * ts - Q_HALF_K * xs - SIN60_Q15_K * ys;
        w[2] = Q_ONE_K * (xs - ts);
        sp = (abs_l(ys) > abs_l(xs)) ? abs_l(ys) : abs_l(xs);
        target = th + (sp * (FULL_DUTY - th)) / FULL_PCT;
        if (target > FULL_DUTY)
            target = FULL_DUTY;
        mmax = 0;
        for (int k = 0; k < 3; k++)
        begin
            m[k] = abs_l(w[k]);
            if (m[k] > mmax)
                mmax = m[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            d = th;
            if (mmax != 0)
                d = th + (m[k] * (target - th)) / mmax;
            if (d > FULL_DUTY)
                d = FULL_DUTY;
            duty[k] = duty_t'(d);
        end
        r.d1 = duty[0];
        r.f1 = (w[0] > 0);
        r.d2 = duty[1];
        r.f2 = (w[1] > 0);
        r.d3 = duty[2];
        r.f3 = (w[2] > 0);
        r.en = 1'b1;
        return r;
    endfunction

    // result check, then prediction of any item taken at this edge, then config
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (rst_n && done)
        begin
            got = '{duty_one, fwd_one, duty_two, fwd_two, duty_three, fwd_three, drive_enable};
            if (pending_drives.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: duty %0d/%0d/%0d fwd %b%b%b en %b",
                             got.d1, got.d2, got.d3, got.f1, got.f2, got.f3, got.en);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (got.d1 !== want.d1 || got.f1 !== want.f1 || got.d2 !== want.d2 ||
                    got.f2 !== want.f2 || got.d3 !== want.d3 || got.f3 !== want.f3 ||
                    got.en !== want.en)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%0d/%0d %b%b%b %b got %0d/%0d/%0d %b%b%b %b",
                                 want.d1, want.d2, want.d3, want.f1, want.f2, want.f3, want.en,
                                 got.d1, got.d2, got.d3, got.f1, got.f2, got.f3, got.en);
                end
            end
        end
        if (rst_n && start && !busy)
            pending_drives.push_back(mix_wheels($signed(vel_x), $signed(vel_y),
                                                $signed(turn_rate), thr_now));
        if (rst_n && cfg_we)
            thr_now = cfg_data;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("three_wheel_omni_pwm_mixer_tb failed");
            $finish;
        end
    end

    task automatic send_cmd(input logic signed [7:0] x, input logic signed [7:0] y,
                            input logic signed [7:0] t);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        vel_x     <= x;
        vel_y     <= y;
        turn_rate <= t;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // hold off until every result is back and the pipeline has emptied
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_vel;
        case ($urandom_range(9))
            0: return 8'd0;
            1: return $urandom_range(1) ? 8'd100 : 8'(-100);
            2: return 8'($urandom);
            default: return 8'($urandom_range(200) - 100);
        endcase
    endfunction

    task automatic test_directed_commands;
        send_cmd(100, 0, 0);
        send_cmd(-100, 0, 0);
        send_cmd(0, 100, 0);
        send_cmd(0, -100, 0);
        send_cmd(100, 100, 100);
        send_cmd(-100, -100, -100);
        send_cmd(100, -100, -100);
        send_cmd(1, 0, 0);
        send_cmd(0, 1, 0);
        send_cmd(-1, -1, 0);
        // out-of-range magnitudes
        send_cmd(-128, -128, -128);
        send_cmd(127, 127, 127);
        send_cmd(-128, 0, 127);
        send_cmd(0, -128, -128);
        // stop command, turn ignored
        send_cmd(0, 0, 0);
        send_cmd(0, 0, 100);
        send_cmd(0, 0, -128);
        send_cmd(0, 0, 127);
        // zero speed on one or two wheels
        send_cmd(50, 0, 50);
        send_cmd(-100, 0, 50);
        send_cmd(100, 0, -50);
        drain();
    endtask

    task automatic test_threshold_extremes;
        logic [7:0] levels[3];
        levels = '{8'd255, 8'd1, 8'd128};
        foreach (levels[i])
        begin
            write_threshold(levels[i]);
            send_cmd(100, 100, 0);
            send_cmd(-128, 5, -100);
            send_cmd(0, 0, 50);
            send_cmd(50, 0, 50);
            send_cmd(1, -1, 100);
            drain();
        end
    endtask

    task automatic test_random_commands;
        int idle_modes[3];
        idle_modes = '{0, 82, 17};
        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: write_threshold(8'd255);
                1: write_threshold(8'd0);
                default: write_threshold(8'($urandom));
            endcase
            idle_pct = idle_modes[p % 3];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(19) == 0)
                    send_cmd(0, 0, rand_vel());
                else
                    send_cmd(rand_vel(), rand_vel(), rand_vel());
            end
            idle_pct = 0;
            drain();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_commands();
        test_threshold_extremes();
        test_random_commands();
        drain();
        if (pending_drives.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("three_wheel_omni_pwm_mixer_tb passed");
        else
            $display("three_wheel_omni_pwm_mixer_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
